// File: hdl/assert_macros.svh
// Assertion macros used by the RTL of the alarm clock block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/acmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm clock package
// Request and result types, command codes, register map and melody table.
// ----------------------------------------------------------------------------
package acmt_pkg;

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_TONE_EDGE   = 3'd1,
    CMD_SET_TIME    = 3'd2,
    CMD_SET_ALARM   = 3'd3,
    CMD_CLEAR_ALARM = 3'd4,
    CMD_SNOOZE      = 3'd5
  } cmd_t;

  localparam int unsigned PADDR_WIDTH = 3;
  localparam logic REG_TICKS_PER_SECOND = 1'b0;
  localparam logic REG_TICKS_PER_NOTE   = 1'b1;

  localparam logic [7:0] TICKS_PER_SECOND_RESET = 8'd80;
  localparam logic [7:0] TICKS_PER_NOTE_RESET   = 8'd45;
  localparam logic [6:0] SECONDS_PER_MINUTE     = 7'd60;
  localparam logic [6:0] MINUTE_LIMIT           = 7'd24;
  localparam logic [6:0] MINUTE_RESET           = 7'd10;
  localparam logic [7:0] ALARM_OFF              = 8'd100;
  localparam logic [7:0] SNOOZE_SECONDS         = 8'd10;
  localparam logic [5:0] MELODY_LAST_INDEX      = 6'd29;
  localparam int unsigned TUNE_LEN              = 30;

  localparam logic [15:0] N_C  = 16'(65536 - 1000000 / 262 / 2);
  localparam logic [15:0] N_D  = 16'(65536 - 1000000 / 294 / 2);
  localparam logic [15:0] N_E  = 16'(65536 - 1000000 / 330 / 2);
  localparam logic [15:0] N_F  = 16'(65536 - 1000000 / 349 / 2);
  localparam logic [15:0] N_G  = 16'(65536 - 1000000 / 392 / 2);
  localparam logic [15:0] N_A  = 16'(65536 - 1000000 / 440 / 2);
  localparam logic [15:0] N_B  = 16'(65536 - 1000000 / 494 / 2);
  localparam logic [15:0] N_HC = 16'(65536 - 1000000 / 524 / 2);

  typedef struct packed {
    cmd_t       command;
    logic [6:0] value_high;
    logic [6:0] value_low;
  } req_t;

  typedef struct packed {
    logic [6:0]  minute_now;
    logic [6:0]  second_now;
    logic [7:0]  alarm_minute_now;
    logic [7:0]  alarm_second_now;
    logic        alarm_playing;
    logic        speaker_level;
    logic [4:0]  note_position;
    logic [15:0] note_reload;
  } rsp_t;

  typedef struct packed {
    logic [7:0] ticks_per_second;
    logic [7:0] ticks_per_note;
  } cfg_t;

  function automatic logic [15:0] tune_reload(input logic [4:0] idx);
    logic [15:0] r;
    unique case (idx)
      5'd0:  r = N_G;
      5'd1:  r = N_C;
      5'd2:  r = N_D;
      5'd3:  r = N_E;
      5'd4:  r = N_F;
      5'd5:  r = N_G;
      5'd6:  r = N_C;
      5'd7:  r = N_C;
      5'd8:  r = N_A;
      5'd9:  r = N_F;
      5'd10: r = N_G;
      5'd11: r = N_A;
      5'd12: r = N_B;
      5'd13: r = N_HC;
      5'd14: r = N_C;
      5'd15: r = N_C;
      5'd16: r = N_F;
      5'd17: r = N_G;
      5'd18: r = N_F;
      5'd19: r = N_E;
      5'd20: r = N_D;
      5'd21: r = N_E;
      5'd22: r = N_F;
      5'd23: r = N_E;
      5'd24: r = N_D;
      5'd25: r = N_C;
      5'd26: r = N_D;
      5'd27: r = N_E;
      5'd28: r = N_C;
      5'd29: r = N_D;
      default: r = N_G;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/acmt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm clock core
// Holds the clock, alarm and melody state and computes the state after each
// accepted request in a single pass.
// ----------------------------------------------------------------------------
module acmt_core
  import acmt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic accept,
  input  req_t req,
  output rsp_t rsp_next
);

  logic [7:0] tick_count, tick_count_next;
  logic [7:0] note_tick_count, note_tick_count_next;
  logic [6:0] second_count, second_count_next;
  logic [6:0] minute_count, minute_count_next;
  logic [7:0] alarm_minute, alarm_minute_next;
  logic [7:0] alarm_second, alarm_second_next;
  logic       playing_flag, playing_flag_next;
  logic       snooze_used, snooze_used_next;
  logic [4:0] note_index, note_index_next;
  logic       speaker_state, speaker_state_next;

  always_comb begin
    logic [7:0] snz;
    tick_count_next      = tick_count;
    note_tick_count_next = note_tick_count;
    second_count_next    = second_count;
    minute_count_next    = minute_count;
    alarm_minute_next    = alarm_minute;
    alarm_second_next    = alarm_second;
    playing_flag_next    = playing_flag;
    snooze_used_next     = snooze_used;
    note_index_next      = note_index;
    speaker_state_next   = speaker_state;
    snz = {1'b0, second_count} + SNOOZE_SECONDS;
    unique case (req.command)
      CMD_TICK: begin
        tick_count_next = tick_count + 8'd1;
        if (tick_count_next == cfg.ticks_per_second) begin
          tick_count_next = '0;
          second_count_next = second_count + 7'd1;
          if (second_count_next == SECONDS_PER_MINUTE) begin
            second_count_next = '0;
            minute_count_next = minute_count + 7'd1;
          end
        end
        note_tick_count_next = note_tick_count + 8'd1;
        if (note_tick_count_next == cfg.ticks_per_note) begin
          note_tick_count_next = '0;
          note_index_next = note_index + 5'd1;
          if ({1'b0, note_index_next} == MELODY_LAST_INDEX) begin
            note_index_next = '0;
          end
        end
        if (minute_count_next >= MINUTE_LIMIT) begin
          minute_count_next = '0;
        end
        if (second_count_next >= SECONDS_PER_MINUTE) begin
          second_count_next = '0;
        end
        if (!playing_flag) begin
          note_index_next = '0;
        end
      end
      CMD_TONE_EDGE: begin
        if ({1'b0, minute_count} == alarm_minute && {1'b0, second_count} == alarm_second) begin
          playing_flag_next = 1'b1;
          snooze_used_next = 1'b0;
        end
        if (playing_flag_next) begin
          speaker_state_next = ~speaker_state;
        end
      end
      CMD_SET_TIME: begin
        minute_count_next = req.value_high;
        second_count_next = req.value_low;
      end
      CMD_SET_ALARM: begin
        alarm_minute_next = {1'b0, req.value_high};
        alarm_second_next = {1'b0, req.value_low};
      end
      CMD_CLEAR_ALARM: begin
        playing_flag_next = 1'b0;
        snooze_used_next = 1'b0;
        alarm_minute_next = ALARM_OFF;
        alarm_second_next = ALARM_OFF;
      end
      CMD_SNOOZE: begin
        playing_flag_next = 1'b0;
        if (!snooze_used) begin
          if (snz >= {1'b0, SECONDS_PER_MINUTE}) begin
            snz = snz - {1'b0, SECONDS_PER_MINUTE};
            alarm_minute_next = alarm_minute + 8'd1;
          end
          alarm_second_next = snz;
          snooze_used_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp_next.minute_now       = minute_count_next;
    rsp_next.second_now       = second_count_next;
    rsp_next.alarm_minute_now = alarm_minute_next;
    rsp_next.alarm_second_now = alarm_second_next;
    rsp_next.alarm_playing    = playing_flag_next;
    rsp_next.speaker_level    = speaker_state_next;
    rsp_next.note_position    = note_index_next;
    rsp_next.note_reload      = tune_reload(note_index_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= '0;
      note_tick_count <= '0;
      second_count    <= '0;
      minute_count    <= MINUTE_RESET;
      alarm_minute    <= ALARM_OFF;
      alarm_second    <= ALARM_OFF;
      playing_flag    <= 1'b0;
      snooze_used     <= 1'b0;
      note_index      <= '0;
      speaker_state   <= 1'b1;
    end else if (accept) begin
      tick_count      <= tick_count_next;
      note_tick_count <= note_tick_count_next;
      second_count    <= second_count_next;
      minute_count    <= minute_count_next;
      alarm_minute    <= alarm_minute_next;
      alarm_second    <= alarm_second_next;
      playing_flag    <= playing_flag_next;
      snooze_used     <= snooze_used_next;
      note_index      <= note_index_next;
      speaker_state   <= speaker_state_next;
    end
  end

endmodule

// File: hdl/alarm_clock_melody_timer.sv
`timescale 1ns / 1ps
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle; the state update is a single pass.
// A new request is taken while the result register is empty or being drained.
// Reset is synchronous: the clock reads 10:00, the alarm is off (100),
// the speaker idles high and the tick registers return to 80 and 45.
// ----------------------------------------------------------------------------
// Alarm clock with melody player
// Top level with the register port, request handshake and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alarm_clock_melody_timer
  import acmt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  req_t                   req,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output rsp_t                   rsp
);

  cfg_t cfg;
  rsp_t rsp_next;
  logic accept;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign req_ready = ~rsp_valid | rsp_ready;
  assign accept    = req_valid & req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_second <= TICKS_PER_SECOND_RESET;
      cfg.ticks_per_note   <= TICKS_PER_NOTE_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_TICKS_PER_SECOND) begin
        cfg.ticks_per_second <= pwdata[7:0];
      end else begin
        cfg.ticks_per_note <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_TICKS_PER_NOTE) begin
      prdata = {24'd0, cfg.ticks_per_note};
    end else begin
      prdata = {24'd0, cfg.ticks_per_second};
    end
  end

  acmt_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .req      (req),
    .rsp_next (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  `ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, rsp_valid)
  `ASSERT_IMPLY(a_stall_blocks_request, clk, rst, rsp_valid && !rsp_ready, !req_ready)
  `ASSERT_NEXT(a_tick_in_range, clk, rst, accept && req.command == CMD_TICK, rsp.minute_now < MINUTE_LIMIT && rsp.second_now < SECONDS_PER_MINUTE)
  `ASSERT_NEXT(a_clear_stops_alarm, clk, rst, accept && req.command == CMD_CLEAR_ALARM, !rsp.alarm_playing && rsp.alarm_minute_now == ALARM_OFF)

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm clock with melody player: testbench
// Drives clock commands through the request channel and register writes
// through the configuration port. A behavioral model of the clock, alarm,
// snooze and melody counters predicts every readout, and each readout is
// checked field by field in order. Requests idle and results stall at random.
// ----------------------------------------------------------------------------
module tb;
  import acmt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam cmd_t CMD_UNUSED_6 = cmd_t'(3'd6);
  localparam cmd_t CMD_UNUSED_7 = cmd_t'(3'd7);

  logic                   clk;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_WIDTH-1:0] paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   req_valid;
  logic                   req_ready;
  req_t                   req;
  logic                   rsp_valid;
  logic                   rsp_ready;
  rsp_t                   rsp;

  alarm_clock_melody_timer i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Model of the clock state and its two tick registers.
  logic [7:0]  cfg_tps;
  logic [7:0]  cfg_tpn;
  logic [7:0]  sec_ticks;
  logic [7:0]  note_ticks;
  logic [6:0]  clk_sec;
  logic [6:0]  clk_min;
  logic [7:0]  alm_min;
  logic [7:0]  alm_sec;
  logic        ringing;
  logic        snoozed;
  logic [4:0]  melody_idx;
  logic        spk;
  logic [15:0] melody_reload [TUNE_LEN] = '{
    N_G, N_C, N_D, N_E, N_F, N_G, N_C, N_C, N_A, N_F,
    N_G, N_A, N_B, N_HC, N_C, N_C, N_F, N_G, N_F, N_E,
    N_D, N_E, N_F, N_E, N_D, N_C, N_D, N_E, N_C, N_D
  };

  rsp_t readouts_due [$];
  int   mismatches;
  int   cycle_count;
  int   stall_left;
  bit   idle_on;
  bit   calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if (idle_on && !calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 15);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_readouts
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (readouts_due.size() == 0) begin
        $error("readout with no request outstanding");
        mismatches++;
      end else begin
        want = readouts_due.pop_front();
        compare_field("minute_now", 16'(want.minute_now), 16'(rsp.minute_now));
        compare_field("second_now", 16'(want.second_now), 16'(rsp.second_now));
        compare_field("alarm_minute_now", 16'(want.alarm_minute_now),
                      16'(rsp.alarm_minute_now));
        compare_field("alarm_second_now", 16'(want.alarm_second_now),
                      16'(rsp.alarm_second_now));
        compare_field("alarm_playing", 16'(want.alarm_playing), 16'(rsp.alarm_playing));
        compare_field("speaker_level", 16'(want.speaker_level), 16'(rsp.speaker_level));
        compare_field("note_position", 16'(want.note_position), 16'(rsp.note_position));
        compare_field("note_reload", want.note_reload, rsp.note_reload);
      end
    end
  end

  task automatic reset_clock_model();
    cfg_tps    = TICKS_PER_SECOND_RESET;
    cfg_tpn    = TICKS_PER_NOTE_RESET;
    sec_ticks  = '0;
    note_ticks = '0;
    clk_sec    = '0;
    clk_min    = MINUTE_RESET;
    alm_min    = ALARM_OFF;
    alm_sec    = ALARM_OFF;
    ringing    = 1'b0;
    snoozed    = 1'b0;
    melody_idx = '0;
    spk        = 1'b1;
  endtask

  function automatic rsp_t advance_clock(input req_t r);
    rsp_t o;
    int   s;
    unique case (r.command)
      CMD_TICK: begin
        sec_ticks = sec_ticks + 8'd1;
        if (sec_ticks == cfg_tps) begin
          sec_ticks = '0;
          clk_sec = clk_sec + 7'd1;
          if (clk_sec == SECONDS_PER_MINUTE) begin
            clk_sec = '0;
            clk_min = clk_min + 7'd1;
          end
        end
        note_ticks = note_ticks + 8'd1;
        if (note_ticks == cfg_tpn) begin
          note_ticks = '0;
          melody_idx = melody_idx + 5'd1;
          if (melody_idx == MELODY_LAST_INDEX) melody_idx = '0;
        end
        if (clk_min >= MINUTE_LIMIT) clk_min = '0;
        if (clk_sec >= SECONDS_PER_MINUTE) clk_sec = '0;
        if (!ringing) melody_idx = '0;
      end
      CMD_TONE_EDGE: begin
        if (clk_min == alm_min && clk_sec == alm_sec) begin
          ringing = 1'b1;
          snoozed = 1'b0;
        end
        if (ringing) spk = ~spk;
      end
      CMD_SET_TIME: begin
        clk_min = r.value_high;
        clk_sec = r.value_low;
      end
      CMD_SET_ALARM: begin
        alm_min = 8'(r.value_high);
        alm_sec = 8'(r.value_low);
      end
      CMD_CLEAR_ALARM: begin
        ringing = 1'b0;
        snoozed = 1'b0;
        alm_min = ALARM_OFF;
        alm_sec = ALARM_OFF;
      end
      CMD_SNOOZE: begin
        ringing = 1'b0;
        if (!snoozed) begin
          s = int'(clk_sec) + int'(SNOOZE_SECONDS);
          if (s >= int'(SECONDS_PER_MINUTE)) begin
            s -= int'(SECONDS_PER_MINUTE);
            alm_min = alm_min + 8'd1;
          end
          alm_sec = 8'(s);
          snoozed = 1'b1;
        end
      end
      default: ;
    endcase
    o.minute_now       = clk_min;
    o.second_now       = clk_sec;
    o.alarm_minute_now = alm_min;
    o.alarm_second_now = alm_sec;
    o.alarm_playing    = ringing;
    o.speaker_level    = spk;
    o.note_position    = melody_idx;
    o.note_reload      = (melody_idx < TUNE_LEN) ? melody_reload[melody_idx]
                                                 : melody_reload[0];
    return o;
  endfunction

  function automatic req_t make_req(input cmd_t op, input logic [6:0] hi,
                                    input logic [6:0] lo);
    req_t r;
    r.command    = op;
    r.value_high = hi;
    r.value_low  = lo;
    return r;
  endfunction

  task automatic issue_request(input req_t r);
    int gap;
    if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
      req_valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    readouts_due.push_back(advance_clock(r));
  endtask

  task automatic wait_for_readouts();
    req_valid <= 1'b0;
    while (readouts_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    logic [31:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_WIDTH'(4 * int'(idx));
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== 32'(value)) begin
      $error("register %0d readback: expected %0d, got %0d", idx, value, readback);
      mismatches++;
    end
    if (idx == REG_TICKS_PER_SECOND) cfg_tps = value;
    else cfg_tpn = value;
  endtask

  // When a counter sits at or above its new nonzero limit, limits one above the
  // counters and a single tick clear both counters first, so that a lower
  // setting does not have to wait for an 8-bit wrap.
  task automatic retune(input logic [7:0] per_second, input logic [7:0] per_note);
    if (!((per_second == 0 || sec_ticks < per_second) &&
          (per_note == 0 || note_ticks < per_note))) begin
      wait_for_readouts();
      write_reg(REG_TICKS_PER_SECOND, sec_ticks + 8'd1);
      write_reg(REG_TICKS_PER_NOTE, note_ticks + 8'd1);
      issue_request(make_req(CMD_TICK, 7'd0, 7'd0));
    end
    wait_for_readouts();
    write_reg(REG_TICKS_PER_SECOND, per_second);
    write_reg(REG_TICKS_PER_NOTE, per_note);
  endtask

  function automatic req_t pick_request(input bit heavy);
    int         roll;
    logic [6:0] hi;
    logic [6:0] lo;
    cmd_t       op;
    roll = $urandom_range(0, 99);
    hi   = 7'($urandom_range(0, 127));
    lo   = 7'($urandom_range(0, 127));
    if ((heavy && $urandom_range(0, 9) < 8) || roll < 45) begin
      op = CMD_TICK;
    end else if (roll < 65) begin
      op = CMD_TONE_EDGE;
    end else if (roll < 73) begin
      op = CMD_SET_TIME;
      if ($urandom_range(0, 7) != 0) begin
        hi = 7'($urandom_range(0, 23));
        lo = 7'($urandom_range(0, 59));
      end
    end else if (roll < 83) begin
      op = CMD_SET_ALARM;
      if ($urandom_range(0, 1) == 1) begin
        hi = clk_min;
        lo = 7'(clk_sec + $urandom_range(0, 2));
      end else if ($urandom_range(0, 7) != 0) begin
        hi = 7'($urandom_range(0, 23));
        lo = 7'($urandom_range(0, 59));
      end
    end else if (roll < 87) begin
      op = CMD_CLEAR_ALARM;
    end else if (roll < 96) begin
      op = CMD_SNOOZE;
    end else begin
      op = roll[0] ? CMD_UNUSED_7 : CMD_UNUSED_6;
    end
    return make_req(op, hi, lo);
  endfunction

  task automatic run_random(input int count, input bit heavy);
    int   done;
    bit   paused;
    req_t r;
    done   = 0;
    paused = 1'b0;
    while (done < count) begin
      r = pick_request(heavy);
      issue_request(r);
      if (r.command != CMD_UNUSED_6 && r.command != CMD_UNUSED_7) done++;
      if (!paused && done == count / 2) begin
        wait_for_readouts();
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_commands();
    idle_on = 1'b1;
    issue_request(make_req(CMD_TICK, 7'd127, 7'd127));
    issue_request(make_req(CMD_TONE_EDGE, 7'd0, 7'd127));
    issue_request(make_req(CMD_UNUSED_6, 7'd127, 7'd127));
    issue_request(make_req(CMD_UNUSED_7, 7'd0, 7'd0));
    issue_request(make_req(CMD_SET_TIME, 7'd127, 7'd127));
    issue_request(make_req(CMD_TICK, 7'd0, 7'd0));
    issue_request(make_req(CMD_SET_TIME, 7'd23, 7'd59));
    issue_request(make_req(CMD_SET_ALARM, 7'd23, 7'd59));
    issue_request(make_req(CMD_TONE_EDGE, 7'd0, 7'd0));
    issue_request(make_req(CMD_TONE_EDGE, 7'd0, 7'd0));
    issue_request(make_req(CMD_SNOOZE, 7'd0, 7'd0));
    issue_request(make_req(CMD_SNOOZE, 7'd0, 7'd0));
    issue_request(make_req(CMD_TONE_EDGE, 7'd0, 7'd0));
    issue_request(make_req(CMD_CLEAR_ALARM, 7'd127, 7'd127));
    issue_request(make_req(CMD_SNOOZE, 7'd0, 7'd0));
    issue_request(make_req(CMD_SET_TIME, 7'd0, 7'd0));
    issue_request(make_req(CMD_SET_ALARM, 7'd0, 7'd0));
    issue_request(make_req(CMD_TONE_EDGE, 7'd0, 7'd0));
    issue_request(make_req(CMD_CLEAR_ALARM, 7'd0, 7'd0));
    issue_request(make_req(CMD_SET_ALARM, 7'd127, 7'd0));
    issue_request(make_req(CMD_SET_TIME, 7'd99, 7'd99));
    issue_request(make_req(CMD_TICK, 7'd0, 7'd0));
    wait_for_readouts();
  endtask

  task automatic test_melody_playback();
    retune(8'd1, 8'd1);
    issue_request(make_req(CMD_SET_TIME, 7'd5, 7'd0));
    issue_request(make_req(CMD_SET_ALARM, 7'd5, 7'd0));
    issue_request(make_req(CMD_TONE_EDGE, 7'd0, 7'd0));
    repeat (100) issue_request(make_req(CMD_TICK, 7'd0, 7'd0));
    issue_request(make_req(CMD_TONE_EDGE, 7'd0, 7'd0));
    issue_request(make_req(CMD_SNOOZE, 7'd0, 7'd0));
    issue_request(make_req(CMD_TICK, 7'd0, 7'd0));
    wait_for_readouts();
  endtask

  task automatic test_random_traffic();
    idle_on = ($urandom_range(0, 3) != 0);
    retune(8'd255, 8'd255);
    run_random(100, 1'b0);
    idle_on = ($urandom_range(0, 3) != 0);
    retune(8'd0, 8'd0);
    run_random(200, 1'b1);
    idle_on = 1'b1;
    retune(8'd1, 8'd1);
    run_random(100, 1'b0);
    idle_on = ($urandom_range(0, 3) != 0);
    retune(8'($urandom_range(2, 20)), 8'($urandom_range(2, 20)));
    run_random(100, 1'b0);
    calm = 1'b1;
    retune(TICKS_PER_SECOND_RESET, TICKS_PER_NOTE_RESET);
    run_random(100, 1'b0);
    wait_for_readouts();
  endtask

  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    req_valid   = 1'b0;
    req         = '0;
    rsp_ready   = 1'b0;
    mismatches  = 0;
    cycle_count = 0;
    stall_left  = 0;
    idle_on     = 1'b0;
    calm        = 1'b0;
    reset_clock_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_commands();
    test_melody_playback();
    test_random_traffic();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
